// ===== rtl/afcsd_pkg.sv =====
// Shared types, constants and the arctangent table for the angle-from-cos/sin block.
// Depends on nothing; every other file in rtl/ imports this package.
package afcsd_pkg;

  // Input sample width and the fraction bits appended before rotation.
  localparam int INPUT_WIDTH = 16;
  localparam int FRAC_BITS   = 16;

  // Micro-rotations requested, and the table length that bounds them.
  localparam int ITERATIONS = 16;
  localparam int TABLE_LEN  = 24;
  localparam int NUM_CELLS  = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam int SHIFT_W    = $clog2(TABLE_LEN);

  // Rotation datapath width: input plus fraction plus growth from
  // pre-rotation and the CORDIC gain.
  localparam int XW = INPUT_WIDTH + FRAC_BITS + 3;

  // Angle accumulator in units of 2^-16 degree; spans about -100 to +280 degrees.
  localparam int AW = 26;

  // Result width and the fixed-point landmarks of the output mapping.
  localparam int ANGLE_W = 19;
  localparam int DEG_ONE = 65536;
  localparam logic signed [AW-1:0] ACC_180 = AW'(180 * DEG_ONE);
  localparam logic [AW:0] DEG_360 = (AW+1)'(360 * DEG_ONE);
  localparam logic signed [AW-1:0] SNAP_LIMIT = -AW'(65);
  localparam int CNT_W = AW + 1 - 6;
  localparam logic [CNT_W-1:0] FULL_CIRCLE = CNT_W'(368640);

  // Axis directions that bypass the rotation chain.
  typedef enum logic [1:0] {
    AXIS_0   = 2'd0,
    AXIS_90  = 2'd1,
    AXIS_180 = 2'd2,
    AXIS_270 = 2'd3
  } axis_e;

  // Data carried from one pipeline stage to the next.
  typedef struct packed {
    logic                   on_axis;
    axis_e                  axis;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [AW-1:0]   acc;
  } stage_t;

  // Arctangent of 2^-i in degrees, rounded to 2^-16 degree.
  function automatic logic signed [AW-1:0] atan_step(input logic [SHIFT_W-1:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return AW'(signed'({1'b0, v}));
  endfunction

endpackage

// ===== rtl/afcsd_pre.sv =====
// Input stage: axis detection, half-plane pre-rotation and scaling to the datapath format.
// Depends on afcsd_pkg.
module afcsd_pre (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   stall_o,
  input  logic signed [afcsd_pkg::INPUT_WIDTH-1:0] cos_i,
  input  logic signed [afcsd_pkg::INPUT_WIDTH-1:0] sin_i,
  output logic                                   valid_o,
  input  logic                                   stall_i,
  output afcsd_pkg::stage_t                      data_o
);
  import afcsd_pkg::*;

  logic   valid_q, load;
  stage_t data_d, data_q;
  logic signed [XW-1:0] x_ext, y_ext;

  // Scale both components by 2^16 and flip the left half-plane by 180 degrees.
  always_comb begin
    x_ext = {{(XW-INPUT_WIDTH-FRAC_BITS){cos_i[INPUT_WIDTH-1]}}, cos_i, FRAC_BITS'(0)};
    y_ext = {{(XW-INPUT_WIDTH-FRAC_BITS){sin_i[INPUT_WIDTH-1]}}, sin_i, FRAC_BITS'(0)};
    data_d.on_axis = (cos_i == '0) || (sin_i == '0);
    if (sin_i == '0) begin
      data_d.axis = cos_i[INPUT_WIDTH-1] ? AXIS_180 : AXIS_0;
    end else if (sin_i[INPUT_WIDTH-1]) begin
      data_d.axis = AXIS_270;
    end else begin
      data_d.axis = AXIS_90;
    end
    if (cos_i[INPUT_WIDTH-1]) begin
      data_d.x   = -x_ext;
      data_d.y   = -y_ext;
      data_d.acc = ACC_180;
    end else begin
      data_d.x   = x_ext;
      data_d.y   = y_ext;
      data_d.acc = '0;
    end
  end

  // A stage takes a new request whenever it is empty or its result moves on.
  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/afcsd_cell.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on afcsd_pkg for the stage record and the arctangent table.
module afcsd_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [afcsd_pkg::SHIFT_W-1:0] shift_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  afcsd_pkg::stage_t             data_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output afcsd_pkg::stage_t             data_o
);
  import afcsd_pkg::*;

  logic   valid_q, load;
  stage_t data_d, data_q;
  logic signed [XW-1:0] dx, dy;
  logic signed [AW-1:0] step;

  // Rotate toward the x axis; arithmetic shifts round toward minus infinity.
  always_comb begin
    dx     = data_i.y >>> shift_i;
    dy     = data_i.x >>> shift_i;
    step   = atan_step(shift_i);
    data_d = data_i;
    if (data_i.y > 0) begin
      data_d.x   = data_i.x + dx;
      data_d.y   = data_i.y - dy;
      data_d.acc = data_i.acc + step;
    end else begin
      data_d.x   = data_i.x - dx;
      data_d.y   = data_i.y + dy;
      data_d.acc = data_i.acc - step;
    end
  end

  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/afcsd_out.sv =====
// Output stage: wraps the accumulated angle into 0 to 360 degrees and rounds to 1/1024 degree.
// Depends on afcsd_pkg.
module afcsd_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  afcsd_pkg::stage_t             data_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [afcsd_pkg::ANGLE_W-1:0] angle_o
);
  import afcsd_pkg::*;

  logic               valid_q, load;
  logic [ANGLE_W-1:0] angle_d, angle_q;
  logic [AW:0]        adj;
  logic [AW:0]        rounded;
  logic [CNT_W-1:0]   count;

  // Snap tiny negatives to zero, lift other negatives by a full turn, then round and wrap.
  always_comb begin
    if (!data_i.acc[AW-1]) begin
      adj = {1'b0, data_i.acc};
    end else if (data_i.acc >= SNAP_LIMIT) begin
      adj = '0;
    end else begin
      adj = {data_i.acc[AW-1], data_i.acc} + DEG_360;
    end
    rounded = adj + (AW+1)'(32);
    count   = rounded[AW:6];
    if (count >= FULL_CIRCLE) begin
      count = count - FULL_CIRCLE;
    end
    if (data_i.on_axis) begin
      unique case (data_i.axis)
        AXIS_0:   angle_d = '0;
        AXIS_90:  angle_d = ANGLE_W'(90 * 1024);
        AXIS_180: angle_d = ANGLE_W'(180 * 1024);
        AXIS_270: angle_d = ANGLE_W'(270 * 1024);
        default:  angle_d = '0;
      endcase
    end else begin
      angle_d = count[ANGLE_W-1:0];
    end
  end

  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      angle_q <= angle_d;
    end
  end

  assign valid_o = valid_q;
  assign angle_o = angle_q;

endmodule

// ===== rtl/angle_from_cos_sin_degrees.sv =====
// Top level of the angle-from-cos/sin block: input stage, chain of CORDIC cells, output stage.
// Depends on afcsd_pkg, afcsd_pre, afcsd_cell and afcsd_out.
//
//   Channel  Handshake                  Payload
//   input    in_valid_i / in_stall_o    cos_value_i, sin_value_i (signed Q1.15)
//   output   out_valid_o / out_stall_i  angle_o (1/1024 degree, 0 to 368639)
//
// One request is taken every cycle while the output does not stall; a result
// passes through one register in the input stage, one per rotation cell and
// one in the output stage.
// Every stage holds its own valid bit and takes new data when it is empty or
// its content moves on, so bubbles close up and stalls back up stage by stage.
// Reset clears all valid bits; the data registers are not reset.
module angle_from_cos_sin_degrees (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [afcsd_pkg::INPUT_WIDTH-1:0] cos_value_i,
  input  logic signed [afcsd_pkg::INPUT_WIDTH-1:0] sin_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [afcsd_pkg::ANGLE_W-1:0]            angle_o
);
  import afcsd_pkg::*;

  // Link k joins stage k-1 to stage k; link 0 leaves the input stage.
  logic   link_valid [NUM_CELLS+1];
  logic   link_stall [NUM_CELLS+1];
  stage_t link_data  [NUM_CELLS+1];

  afcsd_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .cos_i   (cos_value_i),
    .sin_i   (sin_value_i),
    .valid_o (link_valid[0]),
    .stall_i (link_stall[0]),
    .data_o  (link_data[0])
  );

  // One cell per micro-rotation, each with its fixed shift.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    afcsd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (SHIFT_W'(k)),
      .valid_i (link_valid[k]),
      .stall_o (link_stall[k]),
      .data_i  (link_data[k]),
      .valid_o (link_valid[k+1]),
      .stall_i (link_stall[k+1]),
      .data_o  (link_data[k+1])
    );
  end

  afcsd_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[NUM_CELLS]),
    .stall_o (link_stall[NUM_CELLS]),
    .data_i  (link_data[NUM_CELLS]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .angle_o (angle_o)
  );

endmodule
